// ===== design/kvt_pkg.sv =====
package kvt_pkg;

  // Default sizing of the table
  localparam int unsigned DEF_ENTRIES    = 16;
  localparam int unsigned DEF_KEY_BITS   = 32;
  localparam int unsigned DEF_VALUE_BITS = 32;

  // Fixed field widths of the stream items
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;

  // Packed widths: input tdata holds key and value, output tdata holds data and count
  localparam int unsigned IN_TDATA_W  = KEY_W + VALUE_W;
  localparam int unsigned OUT_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED        = 3'd0,
    ST_UPDATED         = 3'd1,
    ST_DELETED         = 3'd2,
    ST_FOUND           = 3'd3,
    ST_NOT_FOUND       = 3'd4,
    ST_FULL_OR_CLEARED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

endpackage

// ===== design/key_value_table_core.sv =====
// Bounded key/value table with ENTRIES slots of unique keys. Each input item carries an
// operation in tuser (insert-or-update, delete, lookup, clear) and produces exactly one result
// item: a status code in tuser, plus the looked-up value and the new entry count in tdata.
// Insert overwrites the value of a present key, else takes the lowest free slot, else reports
// full. Keys and values live in two slot memories with one write port and one registered read
// port each; slot valid bits are flops that reset clears at once, so there is no clearing pass
// after reset. A single key comparator walks the slot memory one slot per cycle. Insert, delete
// and lookup keep the block not ready from acceptance through a read-ahead step, a compare
// step per slot and a commit step; the result is loaded into the output register at the
// commit. A clear skips the scan and keeps the block not ready through the commit step only.
// No new item is accepted until the previous one has committed. The commit holds while the
// previous result still waits for m_axis_tready. The output register decouples the two sides:
// a new item is accepted while the previous result still waits for m_axis_tready. Key bits
// above KEY_BITS are ignored and value bits above VALUE_BITS are dropped.
module key_value_table_core
  import kvt_pkg::*;
#(
  parameter int unsigned ENTRIES    = DEF_ENTRIES,
  parameter int unsigned KEY_BITS   = DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input item
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic [FUNC_W-1:0]      s_axis_tuser,   // [1:0] func
  // result item
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] data, [36:32] count, [39:37] zero
  output logic [STATUS_W-1:0]    m_axis_tuser    // [2:0] status
);

  // Stored widths: only the bits that fit in the stream fields can matter
  localparam int unsigned KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned VW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // Sequencer and item registers
  state_e          state_q, state_d;
  func_e           op_q, op_d;
  logic [KW-1:0]   key_q, key_d;
  logic [VW-1:0]   val_q, val_d;

  // Scan: read address stage and compare stage
  logic [IW-1:0]   rd_idx_q, rd_idx_d;
  logic            issue_q, issue_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]   cmp_idx_q, cmp_idx_d;

  // Scan results
  logic            hit_q, hit_d;
  logic [IW-1:0]   hit_idx_q, hit_idx_d;
  logic [VW-1:0]   hit_val_q, hit_val_d;
  logic            free_q, free_d;
  logic [IW-1:0]   free_idx_q, free_idx_d;

  // Table state
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [KW-1:0]      key_mem [ENTRIES];
  logic [VW-1:0]      val_mem [ENTRIES];
  logic [KW-1:0]      key_rd_q;
  logic [VW-1:0]      val_rd_q;
  logic               key_we, val_we;
  logic [IW-1:0]      wr_idx;

  // Output register
  logic                 out_vld_q, out_vld_d;
  status_e              status_q, status_d;
  logic [DATA_W-1:0]    data_q, data_d;
  logic [COUNT_W-1:0]   count_q, count_d;

  // Commit-time values
  status_e              status_c;
  logic [VW-1:0]        data_c;
  logic                 out_load;
  logic                 key_match;
  logic [VW+DATA_W-1:0] data_ext;
  logic [CW+COUNT_W-1:0] count_ext;

  // The one shared comparator
  assign key_match = cmp_vld_q && valid_q[cmp_idx_q] && (key_rd_q == key_q);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    rd_idx_d   = rd_idx_q;
    issue_d    = issue_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = rd_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_val_d  = hit_val_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q;
    status_d   = status_q;
    data_d     = data_q;
    count_d    = count_q;
    status_c   = ST_NOT_FOUND;
    data_c     = '0;
    out_load   = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_idx     = hit_idx_q;
    data_ext   = '0;
    count_ext  = '0;

    // Drain the output register independently of the sequencer
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          // Latch the item and start the scan at slot zero
          op_d     = func_e'(s_axis_tuser);
          key_d    = s_axis_tdata[KW-1:0];
          val_d    = s_axis_tdata[KEY_W +: VW];
          rd_idx_d = '0;
          issue_d  = 1'b1;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          state_d  = (func_e'(s_axis_tuser) == FUNC_CLEAR) ? S_COMMIT : S_SCAN;
        end
      end

      S_SCAN: begin
        // Advance the read address; the compare stage follows it in the next cycle
        cmp_vld_d = issue_q;
        if (issue_q) begin
          if (rd_idx_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IW'(1);
          end
        end
        if (cmp_vld_q) begin
          // Keep the first match and the lowest free slot
          if (key_match && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            hit_val_d = val_rd_q;
          end
          if (!valid_q[cmp_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (cmp_idx_q == LAST_IDX) begin
            state_d = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        // Hold here until the output register has room
        out_load = !out_vld_q || m_axis_tready;
        unique case (op_q)
          FUNC_INSERT: begin
            if (hit_q) begin
              status_c = ST_UPDATED;
              val_we   = out_load;
              wr_idx   = hit_idx_q;
            end else if (free_q) begin
              status_c = ST_INSERTED;
              key_we   = out_load;
              val_we   = out_load;
              wr_idx   = free_idx_q;
              if (out_load) begin
                valid_d[free_idx_q] = 1'b1;
                cnt_d               = cnt_q + CW'(1);
              end
            end else begin
              status_c = ST_FULL_OR_CLEARED;
            end
          end
          FUNC_DELETE: begin
            if (hit_q) begin
              status_c = ST_DELETED;
              if (out_load) begin
                valid_d[hit_idx_q] = 1'b0;
                cnt_d              = cnt_q - CW'(1);
              end
            end else begin
              status_c = ST_NOT_FOUND;
            end
          end
          FUNC_LOOKUP: begin
            if (hit_q) begin
              status_c = ST_FOUND;
              data_c   = hit_val_q;
            end else begin
              status_c = ST_NOT_FOUND;
            end
          end
          FUNC_CLEAR: begin
            status_c = ST_FULL_OR_CLEARED;
            if (out_load) begin
              valid_d = '0;
              cnt_d   = '0;
            end
          end
          default: begin
            status_c = ST_NOT_FOUND;
          end
        endcase
        if (out_load) begin
          data_ext  = {{DATA_W{1'b0}}, data_c};
          count_ext = {{COUNT_W{1'b0}}, cnt_d};
          out_vld_d = 1'b1;
          status_d  = status_c;
          data_d    = data_ext[DATA_W-1:0];
          count_d   = count_ext[COUNT_W-1:0];
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issue_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      valid_q   <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_val_q  <= hit_val_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    data_q     <= data_d;
    count_q    <= count_d;
  end

  // Slot memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    key_rd_q <= key_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_idx] <= val_q;
    end
    val_rd_q <= val_mem[rd_idx_q];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - COUNT_W){1'b0}}, count_q, data_q};

`ifndef SYNTHESIS
  // Entry count always matches the number of valid slots
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q))
    else $error("entry count differs from number of valid slots");

  // A committed insert into a free slot grows the count by one and marks the slot
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && out_load && op_q == FUNC_INSERT && !hit_q && free_q)
    |=> (cnt_q == $past(cnt_q) + CW'(1)) && valid_q[$past(free_idx_q)])
    else $error("insert did not claim the free slot");

  // A committed delete of a present key frees its slot
  a_delete_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && out_load && op_q == FUNC_DELETE && hit_q)
    |=> !valid_q[$past(hit_idx_q)])
    else $error("delete left the slot valid");

  // Only a successful lookup carries nonzero data
  a_data_only_on_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_FOUND) |-> (data_q == '0))
    else $error("nonzero data on a result other than found");

  // A cleared table reports zero entries
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && out_load && op_q == FUNC_CLEAR)
    |=> (valid_q == '0) && (count_q == '0))
    else $error("clear left valid slots");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import kvt_pkg::*;

  localparam int unsigned ENTRIES     = DEF_ENTRIES;
  localparam int unsigned KEY_BITS    = DEF_KEY_BITS;
  localparam int unsigned VALUE_BITS  = DEF_VALUE_BITS;
  localparam logic [KEY_W-1:0]   KEY_MASK   = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
  localparam int unsigned ITEMS_PER_PHASE = 362;
  localparam int unsigned KEY_POOL_SIZE   = 32;
  localparam int unsigned DRAIN_CYCLES    = 2 * (ENTRIES + 2) + 8;
  localparam int unsigned CYCLE_LIMIT     = 500000;

  typedef struct packed {
    func_e            func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } kv_op_t;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
  } kv_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  key_value_table_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Shadow copy of the table
  logic               slot_used [ENTRIES];
  logic [KEY_W-1:0]   slot_key  [ENTRIES];
  logic [VALUE_W-1:0] slot_value[ENTRIES];
  int unsigned        entry_total;

  kv_op_t      pending_ops[$];
  kv_result_t  expected_results[$];
  logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          op_taken;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned status_seen[6];
  int unsigned cycle_count;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow table and return the result it must produce.
  function automatic kv_result_t table_apply(input kv_op_t op);
    kv_result_t       res;
    int               hit;
    int               free_slot;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;
    k = op.key & KEY_MASK;
    v = op.value & VALUE_MASK;
    res.status = ST_NOT_FOUND;
    res.data = '0;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == k && hit < 0) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    case (op.func)
      FUNC_INSERT: begin
        if (hit >= 0) begin
          slot_value[hit] = v;
          res.status = ST_UPDATED;
        end else if (free_slot >= 0) begin
          slot_used[free_slot] = 1'b1;
          slot_key[free_slot] = k;
          slot_value[free_slot] = v;
          entry_total++;
          res.status = ST_INSERTED;
        end else begin
          res.status = ST_FULL_OR_CLEARED;
        end
      end
      FUNC_DELETE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          if (entry_total > 0) entry_total--;
          res.status = ST_DELETED;
        end
      end
      FUNC_LOOKUP: begin
        if (hit >= 0) begin
          res.data = slot_value[hit];
          res.status = ST_FOUND;
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
        entry_total = 0;
        res.status = ST_FULL_OR_CLEARED;
      end
    endcase
    res.count = entry_total[COUNT_W-1:0];
    return res;
  endfunction

  task automatic queue_op(input func_e func, input logic [KEY_W-1:0] key,
                          input logic [VALUE_W-1:0] value);
    kv_op_t op;
    op.func = func;
    op.key = key;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  // Mostly keys from a small pool so hits, updates and a full table are common;
  // some fully random keys as noise.
  task automatic queue_random_op();
    int unsigned      pick;
    func_e            func;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 48) func = FUNC_INSERT;
    else if (pick < 68) func = FUNC_DELETE;
    else if (pick < 99) func = FUNC_LOOKUP;
    else func = FUNC_CLEAR;
    if ($urandom_range(9) == 0) key = $urandom;
    else key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    queue_op(func, key, $urandom);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: present a new item once the current one is taken; change inputs on the falling edge.
  always @(negedge clk_i) begin
    kv_op_t op;
    if (rst_ni) begin
      if (!s_axis_tvalid || op_taken) begin
        op_taken = 1'b0;
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {op.value, op.key};
          s_axis_tuser  <= op.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on accepted input items, check accepted result items.
  always @(posedge clk_i) begin
    kv_op_t     op;
    kv_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        op.func  = func_e'(s_axis_tuser);
        op.key   = s_axis_tdata[KEY_W-1:0];
        op.value = s_axis_tdata[KEY_W +: VALUE_W];
        expected_results.push_back(table_apply(op));
        op_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result status %0d data %h count %0d", $time,
                   m_axis_tuser, m_axis_tdata[DATA_W-1:0], m_axis_tdata[DATA_W +: COUNT_W]);
        end else begin
          want = expected_results.pop_front();
          status_seen[want.status]++;
          if (m_axis_tuser !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d got %0d", $time, want.status, m_axis_tuser);
          end
          if (m_axis_tdata[DATA_W-1:0] !== want.data) begin
            mismatches++;
            $display("%0t: data expected %h got %h", $time, want.data,
                     m_axis_tdata[DATA_W-1:0]);
          end
          if (m_axis_tdata[DATA_W +: COUNT_W] !== want.count) begin
            mismatches++;
            $display("%0t: count expected %0d got %0d", $time, want.count,
                     m_axis_tdata[DATA_W +: COUNT_W]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
    end
    entry_total = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    op_taken = 1'b0;
    mismatches = 0;
    results_seen = 0;
    cycle_count = 0;
    for (int i = 0; i < 6; i++) status_seen[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, key and value extremes, update, delete, fill to full.
    queue_op(FUNC_LOOKUP, '0, '1);
    queue_op(FUNC_DELETE, '1, '0);
    queue_op(FUNC_CLEAR, '1, '1);
    queue_op(FUNC_INSERT, '0, '0);
    queue_op(FUNC_INSERT, '1, '1);
    queue_op(FUNC_INSERT, '1, 32'h5a5a_a5a5);
    queue_op(FUNC_LOOKUP, '1, '0);
    queue_op(FUNC_LOOKUP, '0, '1);
    queue_op(FUNC_DELETE, '0, '1);
    queue_op(FUNC_LOOKUP, '0, '0);
    for (int i = 0; i < ENTRIES - 1; i++)
      queue_op(FUNC_INSERT, 32'h8000_0000 >> i, ~(32'h8000_0000 >> i));
    queue_op(FUNC_INSERT, 32'h0000_1234, 32'hdead_beef);
    queue_op(FUNC_INSERT, '1, '0);
    queue_op(FUNC_DELETE, 32'h8000_0000, '0);
    queue_op(FUNC_INSERT, 32'h0000_1234, 32'hdead_beef);
    queue_op(FUNC_CLEAR, '0, '0);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) queue_random_op();
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // Catch any stray result after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("results checked: %0d over 4 idling phases, %0d mismatches", results_seen,
             mismatches);
    $display("statuses: inserted %0d updated %0d deleted %0d found %0d absent %0d full/clear %0d",
             status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_DELETED],
             status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], status_seen[ST_FULL_OR_CLEARED]);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
